// File: hw/rtl/ihtc_pkg.sv
// Package for the image header TLV checker.
// Holds the result record type, the status, kind and parse phase codes, and the
// signature and CRC helper functions. It depends on nothing else.
`default_nettype none

package ihtc_pkg;

  // Header geometry and field limits.
  localparam logic [31:0] CRC_POLY    = 32'h04C1_1DB7;
  localparam logic [7:0]  MAX_VAR_LEN = 8'd127;
  localparam logic [7:0]  NOP_TAG     = 8'hFF;
  localparam logic [11:0] POS_MAX     = 12'd4095;
  localparam logic [12:0] HDR_UNIT    = 13'd16;

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_FIXED     = 2'd0,
    KIND_VAR_START = 2'd1,
    KIND_VAR_DATA  = 2'd2,
    KIND_VERDICT   = 2'd3
  } kind_t;

  // Verdict status codes.
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_SHORT     = 3'd1,
    ST_SIGNATURE = 3'd2,
    ST_SIZE      = 3'd3,
    ST_CRC       = 3'd4,
    ST_FIELD_LEN = 3'd5,
    ST_OVERRUN   = 3'd6
  } status_t;

  // Field parser phases.
  typedef enum logic [2:0] {
    PH_TAG  = 3'd0,
    PH_LEN  = 3'd1,
    PH_FIX  = 3'd2,
    PH_VAR  = 3'd3,
    PH_DONE = 3'd4
  } phase_t;

  // One result item as it sits in the output queue.
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  tag;
    logic [31:0] value;
    logic        field_end;
    status_t     status;
    logic        crc_match;
    logic [31:0] stored_crc;
    logic [11:0] header_length;
  } result_t;

  // Expected signature byte at header offsets zero to three.
  function automatic logic [7:0] sig_byte(input logic [1:0] idx);
    logic [7:0] s;
    unique case (idx)
      2'd0: s = 8'h41;
      2'd1: s = 8'h69;
      2'd2: s = 8'h30;
      default: s = 8'hB9;
    endcase
    return s;
  endfunction

  // MSB-first CRC-32 update by one byte.
  function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
    logic [31:0] c;
    c = c_in ^ {b, 24'd0};
    for (int i = 0; i < 8; i++) begin
      c = c[31] ? ({c[30:0], 1'b0} ^ CRC_POLY) : {c[30:0], 1'b0};
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/ihtc_if.sv
// Channel interfaces for the image header TLV checker: byte input, result
// output and configuration write. It depends on no other file.
`default_nettype none

// Input byte channel.
interface ihtc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last;
  modport source (output valid, output data_byte, output last, input ready);
  modport sink   (input valid, input data_byte, input last, output ready);
endinterface

// Result channel.
interface ihtc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  tag;
  logic [31:0] value;
  logic        field_end;
  logic [2:0]  status;
  logic        crc_match;
  logic [31:0] stored_crc;
  logic [11:0] header_length;
  modport source (output valid, output kind, output tag, output value, output field_end,
                  output status, output crc_match, output stored_crc,
                  output header_length, input ready);
  modport sink   (input valid, input kind, input tag, input value, input field_end,
                  input status, input crc_match, input stored_crc,
                  input header_length, output ready);
endinterface

// Configuration write channel carrying the CRC error waiver bit.
interface ihtc_cfg_if;
  logic valid;
  logic ready;
  logic data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/image_header_tlv_checker_top.sv
// Top level of the image header TLV checker: per-byte header parser, CRC-32
// and verdict logic feeding a four-entry result queue. Uses ihtc_pkg, ihtc_if.
//
//   channel  | dir | payload                                   | accepted when
//   in_ch    | in  | data_byte, last                           | valid && ready
//   out_ch   | out | kind, tag, value, field_end, status,      | valid && ready
//            |     | crc_match, stored_crc, header_length      |
//   cfg_ch   | in  | data (CRC error waiver bit)               | valid && ready
//
// One byte is taken per cycle; its results enter the queue at that same edge
// and can leave it from the next edge on.
// A byte makes at most two results, so in_ch.ready drops while fewer than two
// queue slots are free; a stalled out_ch fills the queue and then stalls in_ch.
// The queue drains one result per cycle. cfg_ch is always ready.
// Synchronous active-low reset clears all parser state and the register.
`default_nettype none

module image_header_tlv_checker_top (
  input  wire logic clk,
  input  wire logic rst_n,
  ihtc_in_if.sink    in_ch,
  ihtc_out_if.source out_ch,
  ihtc_cfg_if.sink   cfg_ch
);
  import ihtc_pkg::*;

  localparam int unsigned QDEPTH = 4;

  // Parser state.
  logic [11:0] pos_r,  pos_nxt;
  logic [11:0] hdr_r,  hdr_nxt;
  logic [31:0] crc_r,  crc_nxt;
  phase_t      phase_r, phase_nxt;
  logic [7:0]  ftag_r, ftag_nxt;
  logic [6:0]  left_r, left_nxt;
  logic [31:0] acc_r,  acc_nxt;
  logic [31:0] cws_r,  cws_nxt;
  logic [2:0]  err_r,  err_nxt;
  logic        vgiven_r, vgiven_nxt;
  logic        ign_crc_r;

  // Result queue.
  result_t     q_mem_r [QDEPTH];
  logic [1:0]  q_head_r, q_tail_r;
  logic [2:0]  q_cnt_r;

  logic        in_fire, out_fire;
  logic        f_valid, v_valid;
  result_t     f_res, v_res;

  // Values after the restart that follows a verdict.
  logic [11:0] p;
  logic [11:0] cur_hdr;
  logic [31:0] cur_crc, cur_acc, cur_cws;
  phase_t      cur_phase;
  logic [7:0]  cur_ftag, b;
  logic [6:0]  cur_left, left_dec;
  logic [2:0]  cur_err;
  logic [12:0] p4, h13, total;
  logic        h_ok, crc_match;
  status_t     st;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_fire = out_ch.valid && out_ch.ready;
  assign in_ch.ready  = (q_cnt_r <= 3'(QDEPTH - 2));
  assign cfg_ch.ready = 1'b1;

  // Per-byte parsing, CRC and verdict.
  always_comb begin
    b         = in_ch.data_byte;
    p         = vgiven_r ? '0 : pos_r;
    cur_hdr   = vgiven_r ? '0 : hdr_r;
    cur_crc   = vgiven_r ? '0 : crc_r;
    cur_phase = vgiven_r ? PH_TAG : phase_r;
    cur_ftag  = vgiven_r ? '0 : ftag_r;
    cur_left  = vgiven_r ? '0 : left_r;
    cur_acc   = vgiven_r ? '0 : acc_r;
    cur_cws   = vgiven_r ? '0 : cws_r;
    cur_err   = vgiven_r ? '0 : err_r;

    pos_nxt    = p;
    hdr_nxt    = cur_hdr;
    crc_nxt    = cur_crc;
    phase_nxt  = cur_phase;
    ftag_nxt   = cur_ftag;
    left_nxt   = cur_left;
    acc_nxt    = cur_acc;
    cws_nxt    = cur_cws;
    err_nxt    = cur_err;
    vgiven_nxt = 1'b0;
    left_dec   = cur_left - 7'd1;

    f_valid = 1'b0;
    f_res   = '0;

    // Signature and size byte.
    if (p < 12'd4) begin
      if (b != sig_byte(p[1:0]) && err_nxt == ST_OK) err_nxt = ST_SIGNATURE;
    end else if (p == 12'd4) begin
      hdr_nxt = {b, 4'd0};
      if (b == 8'd0 && err_nxt == ST_OK) err_nxt = ST_SIZE;
    end

    h13  = {1'b0, hdr_nxt};
    p4   = {1'b0, p} + 13'd4;
    h_ok = (h13 >= HDR_UNIT);

    // CRC over the header body, and capture of the stored CRC word.
    if (p <= 12'd4 || (h_ok && p4 < h13)) crc_nxt = crc_byte(cur_crc, b);
    if (h_ok && p4 >= h13 && {1'b0, p} < h13) cws_nxt = {cur_cws[23:0], b};

    // Field decoder.
    if (p >= 12'd5 && h_ok && err_nxt == ST_OK && cur_phase != PH_DONE) begin
      if (p4 < h13) begin
        unique case (cur_phase)
          PH_TAG: begin
            ftag_nxt = b;
            unique case (b[1:0])
              2'd3: begin
                if (b != NOP_TAG) begin
                  f_valid = 1'b1;
                  f_res.kind = KIND_FIXED;
                  f_res.tag = b;
                  f_res.field_end = 1'b1;
                end
              end
              2'd2: begin
                left_nxt = 7'd1; acc_nxt = '0; phase_nxt = PH_FIX;
              end
              2'd1: begin
                left_nxt = 7'd4; acc_nxt = '0; phase_nxt = PH_FIX;
              end
              default: phase_nxt = PH_LEN;
            endcase
          end
          PH_LEN: begin
            if (b > MAX_VAR_LEN) begin
              err_nxt = ST_FIELD_LEN; phase_nxt = PH_DONE;
            end else begin
              f_valid = 1'b1;
              f_res.kind = KIND_VAR_START;
              f_res.tag = cur_ftag;
              f_res.value = {24'd0, b};
              f_res.field_end = (b == 8'd0);
              if (b == 8'd0) begin
                phase_nxt = PH_TAG;
              end else begin
                left_nxt = b[6:0]; phase_nxt = PH_VAR;
              end
            end
          end
          PH_FIX: begin
            acc_nxt  = {cur_acc[23:0], b};
            left_nxt = left_dec;
            if (left_dec == 7'd0) begin
              f_valid = 1'b1;
              f_res.kind = KIND_FIXED;
              f_res.tag = cur_ftag;
              f_res.value = acc_nxt;
              f_res.field_end = 1'b1;
              phase_nxt = PH_TAG;
            end
          end
          PH_VAR: begin
            left_nxt = left_dec;
            f_valid = 1'b1;
            f_res.kind = KIND_VAR_DATA;
            f_res.tag = cur_ftag;
            f_res.value = {24'd0, b};
            f_res.field_end = (left_dec == 7'd0);
            if (left_dec == 7'd0) phase_nxt = PH_TAG;
          end
          default: ;
        endcase
      end else if (p4 == h13) begin
        // First CRC byte: any open field has run into the CRC word.
        if (cur_phase == PH_LEN) begin
          err_nxt = (b > MAX_VAR_LEN) ? ST_FIELD_LEN : ST_OVERRUN;
        end else if (cur_phase == PH_FIX || cur_phase == PH_VAR) begin
          err_nxt = ST_OVERRUN;
        end
        phase_nxt = PH_DONE;
      end
    end

    if (p < POS_MAX) pos_nxt = p + 12'd1;

    // Verdict on the last byte, checks in priority order.
    total     = {1'b0, p} + 13'd1;
    crc_match = (cws_nxt == crc_nxt);
    priority if (total < HDR_UNIT)                       st = ST_SHORT;
    else if (err_nxt == ST_SIGNATURE)                    st = ST_SIGNATURE;
    else if (err_nxt == ST_SIZE || h13 > total)          st = ST_SIZE;
    else if (!crc_match && !ign_crc_r)                   st = ST_CRC;
    else                                                 st = status_t'(err_nxt);

    v_valid = in_ch.last;
    v_res   = '0;
    v_res.kind = KIND_VERDICT;
    v_res.status = st;
    v_res.header_length = hdr_nxt;
    if (!(st == ST_SHORT || st == ST_SIGNATURE || st == ST_SIZE)) begin
      v_res.value      = crc_nxt;
      v_res.crc_match  = crc_match;
      v_res.stored_crc = cws_nxt;
    end
    if (in_ch.last) vgiven_nxt = 1'b1;
  end

  // Parser state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      hdr_r    <= '0;
      crc_r    <= '0;
      phase_r  <= PH_TAG;
      ftag_r   <= '0;
      left_r   <= '0;
      acc_r    <= '0;
      cws_r    <= '0;
      err_r    <= '0;
      vgiven_r <= 1'b0;
    end else if (in_fire) begin
      pos_r    <= pos_nxt;
      hdr_r    <= hdr_nxt;
      crc_r    <= crc_nxt;
      phase_r  <= phase_nxt;
      ftag_r   <= ftag_nxt;
      left_r   <= left_nxt;
      acc_r    <= acc_nxt;
      cws_r    <= cws_nxt;
      err_r    <= err_nxt;
      vgiven_r <= vgiven_nxt;
    end
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ign_crc_r <= 1'b0;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      ign_crc_r <= cfg_ch.data;
    end
  end

  // Result queue: field result first, then the verdict.
  logic [1:0] n_push;
  logic [1:0] tail_p1;
  always_comb begin
    n_push  = in_fire ? (2'(f_valid) + 2'(v_valid)) : 2'd0;
    tail_p1 = q_tail_r + 2'd1;
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      if (f_valid) begin
        q_mem_r[q_tail_r] <= f_res;
        if (v_valid) q_mem_r[tail_p1] <= v_res;
      end else if (v_valid) begin
        q_mem_r[q_tail_r] <= v_res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_head_r <= '0;
      q_tail_r <= '0;
      q_cnt_r  <= '0;
    end else begin
      q_tail_r <= q_tail_r + n_push;
      if (out_fire) q_head_r <= q_head_r + 2'd1;
      q_cnt_r <= q_cnt_r + {1'b0, n_push} - {2'd0, out_fire};
    end
  end

  // Output channel driven from the queue head.
  result_t head;
  assign head                 = q_mem_r[q_head_r];
  assign out_ch.valid         = (q_cnt_r != 3'd0);
  assign out_ch.kind          = head.kind;
  assign out_ch.tag           = head.tag;
  assign out_ch.value         = head.value;
  assign out_ch.field_end     = head.field_end;
  assign out_ch.status        = head.status;
  assign out_ch.crc_match     = head.crc_match;
  assign out_ch.stored_crc    = head.stored_crc;
  assign out_ch.header_length = head.header_length;

endmodule

`default_nettype wire

// File: dv/image_header_tlv_checker_top_tb.sv
// Self-checking testbench for image_header_tlv_checker_top: builds byte streams
// of image headers, predicts every field and verdict item, and checks the results.
// Depends on ihtc_pkg and the channel interfaces in ihtc_if.

module image_header_tlv_checker_top_tb;
  import ihtc_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int PHASE_BYTES = 90;
  localparam logic [7:0] SIGNATURE [4] = '{8'h41, 8'h69, 8'h30, 8'hB9};

  // Kinds of stream the generator can build.
  typedef enum int {
    S_GOOD, S_OVERRUN, S_BAD_LEN, S_CRC_HIT, S_SIG_HIT, S_SIZE_ZERO, S_CUT, S_HUGE, S_NOISE
  } flavor_t;

  // MSB-first CRC-32 over one byte, polynomial 04C11DB7.
  function automatic logic [31:0] crc32_shift_byte(logic [31:0] c_in, logic [7:0] b);
    logic [31:0] c;
    c = c_in ^ {b, 24'h0};
    for (int i = 0; i < 8; i++) begin
      c = c[31] ? ((c << 1) ^ 32'h04C1_1DB7) : (c << 1);
    end
    return c;
  endfunction

  // Header parser predictor plus the queue of results it still expects.
  class header_verdict_ledger;
    bit          ignore_crc;
    logic [11:0] pos;
    logic [11:0] hdr_len;
    logic [31:0] crc_acc;
    logic [31:0] crc_seen;
    phase_t      phase;
    logic [7:0]  ftag;
    logic [6:0]  left;
    logic [31:0] acc;
    status_t     fault;
    bit          verdict_done;
    result_t     expected_results[$];
    int          mismatches;
    int          checked;
    int          bytes_seen;
    int          verdicts_by_status[8];

    function new();
      ignore_crc = 1'b0;
      clear_stream();
    endfunction

    function void clear_stream();
      pos = '0;
      hdr_len = '0;
      crc_acc = '0;
      crc_seen = '0;
      phase = PH_TAG;
      ftag = '0;
      left = '0;
      acc = '0;
      fault = ST_OK;
      verdict_done = 1'b0;
    endfunction

    function void add_result(kind_t k, logic [7:0] t, logic [31:0] v, logic fe, status_t st,
                             logic m, logic [31:0] sc, logic [11:0] hl);
      result_t r;
      r.kind = k;
      r.tag = t;
      r.value = v;
      r.field_end = fe;
      r.status = st;
      r.crc_match = m;
      r.stored_crc = sc;
      r.header_length = hl;
      expected_results.insert(expected_results.size(), r);
    endfunction

    // Tag-length-value decoding of one byte inside the field area.
    function void decode_field(logic [7:0] b);
      case (phase)
        PH_TAG: begin
          ftag = b;
          case (b[1:0])
            2'b11: begin
              if (b != NOP_TAG) add_result(KIND_FIXED, b, '0, 1'b1, ST_OK, 1'b0, '0, '0);
            end
            2'b10: begin
              left = 7'd1;
              acc = '0;
              phase = PH_FIX;
            end
            2'b01: begin
              left = 7'd4;
              acc = '0;
              phase = PH_FIX;
            end
            default: phase = PH_LEN;
          endcase
        end
        PH_LEN: begin
          if (b > MAX_VAR_LEN) begin
            fault = ST_FIELD_LEN;
            phase = PH_DONE;
          end else begin
            add_result(KIND_VAR_START, ftag, {24'h0, b}, b == 8'd0, ST_OK, 1'b0, '0, '0);
            if (b == 8'd0) begin
              phase = PH_TAG;
            end else begin
              left = b[6:0];
              phase = PH_VAR;
            end
          end
        end
        PH_FIX: begin
          acc = {acc[23:0], b};
          left = left - 7'd1;
          if (left == 7'd0) begin
            add_result(KIND_FIXED, ftag, acc, 1'b1, ST_OK, 1'b0, '0, '0);
            phase = PH_TAG;
          end
        end
        PH_VAR: begin
          left = left - 7'd1;
          add_result(KIND_VAR_DATA, ftag, {24'h0, b}, left == 7'd0, ST_OK, 1'b0, '0, '0);
          if (left == 7'd0) phase = PH_TAG;
        end
        default: ;
      endcase
    endfunction

    // Accepted input item: advance the stream state and queue its results.
    function void note_byte(logic [7:0] b, logic lst);
      int      p;
      int      h;
      int      total;
      bit      match;
      status_t st;
      bytes_seen++;
      if (verdict_done) clear_stream();
      p = pos;
      if (p < 4) begin
        if (b != SIGNATURE[p] && fault == ST_OK) fault = ST_SIGNATURE;
      end else if (p == 4) begin
        hdr_len = {b, 4'h0};
        if (b == 8'd0 && fault == ST_OK) fault = ST_SIZE;
      end
      h = hdr_len;

      // CRC covers the signature, size byte and fields; the last four bytes hold it.
      if (p <= 4 || (h >= HDR_UNIT && p + 4 < h)) crc_acc = crc32_shift_byte(crc_acc, b);
      if (h >= HDR_UNIT && p + 4 >= h && p < h) crc_seen = {crc_seen[23:0], b};

      if (p >= 5 && h >= HDR_UNIT && fault == ST_OK && phase != PH_DONE) begin
        if (p + 4 < h) begin
          decode_field(b);
        end else if (p + 4 == h) begin
          // A field still open when the CRC word starts is an overrun.
          if (phase == PH_LEN) fault = (b > MAX_VAR_LEN) ? ST_FIELD_LEN : ST_OVERRUN;
          else if (phase == PH_FIX || phase == PH_VAR) fault = ST_OVERRUN;
          phase = PH_DONE;
        end
      end
      if (pos < POS_MAX) pos = pos + 12'd1;

      if (lst) begin
        total = p + 1;
        match = (crc_seen == crc_acc);
        if (total < HDR_UNIT) st = ST_SHORT;
        else if (fault == ST_SIGNATURE) st = ST_SIGNATURE;
        else if (fault == ST_SIZE || h > total) st = ST_SIZE;
        else if (!match && !ignore_crc) st = ST_CRC;
        else st = fault;
        if (st == ST_SHORT || st == ST_SIGNATURE || st == ST_SIZE)
          add_result(KIND_VERDICT, '0, '0, 1'b0, st, 1'b0, '0, hdr_len);
        else
          add_result(KIND_VERDICT, '0, crc_acc, 1'b0, st, match, crc_seen, hdr_len);
        verdict_done = 1'b1;
      end
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      mismatches++;
      $display("MISMATCH result %0d, %s: got 0x%0h, expected 0x%0h", checked, what, got,
               want);
    endtask

    // Accepted result item: compare it with the oldest expectation.
    task check_result(result_t got);
      result_t want;
      if (expected_results.size() == 0) begin
        report_mismatch("result with none expected, kind", got.kind, '0);
        return;
      end
      want = expected_results.pop_front();
      if (got.kind !== want.kind) report_mismatch("kind", got.kind, want.kind);
      if (got.tag !== want.tag) report_mismatch("tag", got.tag, want.tag);
      if (got.value !== want.value) report_mismatch("value", got.value, want.value);
      if (got.field_end !== want.field_end)
        report_mismatch("field_end", got.field_end, want.field_end);
      if (got.status !== want.status) report_mismatch("status", got.status, want.status);
      if (got.crc_match !== want.crc_match)
        report_mismatch("crc_match", got.crc_match, want.crc_match);
      if (got.stored_crc !== want.stored_crc)
        report_mismatch("stored_crc", got.stored_crc, want.stored_crc);
      if (got.header_length !== want.header_length)
        report_mismatch("header_length", got.header_length, want.header_length);
      if (want.kind == KIND_VERDICT) verdicts_by_status[want.status]++;
      checked++;
    endtask
  endclass

  logic clk;
  logic rst_n;
  bit   calm;
  int   cycles;
  logic [7:0] stream_q[$];
  header_verdict_ledger ledger;

  // Append one byte to the stream being built.
  function automatic void put_byte(logic [7:0] v);
    stream_q.insert(stream_q.size(), v);
  endfunction

  ihtc_in_if  in_if();
  ihtc_out_if out_if();
  ihtc_cfg_if cfg_if();

  image_header_tlv_checker_top u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  // Free-running clock, period of two units.
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Run watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Test completed with failures");
      $finish;
    end
  end

  // Mostly short, occasionally long gaps in taking result items.
  initial begin
    int hold;
    hold = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        out_if.ready <= 1'b0;
        hold--;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        hold = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
        out_if.ready <= 1'b0;
        hold--;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Check every accepted result item.
  always @(posedge clk) begin : watch_results
    result_t seen;
    if (rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      seen.kind = kind_t'(out_if.kind);
      seen.tag = out_if.tag;
      seen.value = out_if.value;
      seen.field_end = out_if.field_end;
      seen.status = status_t'(out_if.status);
      seen.crc_match = out_if.crc_match;
      seen.stored_crc = out_if.stored_crc;
      seen.header_length = out_if.header_length;
      ledger.check_result(seen);
    end
  end

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 15);
    if (r < 8) return 0;
    if (r < 14) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Offer one item and hold it until the block takes it.
  task send_byte(logic [7:0] b, logic lst);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data_byte <= b;
    in_if.last <= lst;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    ledger.note_byte(b, lst);
  endtask

  task send_stream();
    for (int i = 0; i < stream_q.size(); i++) send_byte(stream_q[i], i == stream_q.size() - 1);
  endtask

  // Let the block finish everything it holds before going on.
  task drain_results();
    in_if.valid <= 1'b0;
    while (ledger.expected_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task write_ignore_crc(bit v);
    cfg_if.valid <= 1'b1;
    cfg_if.data <= v;
    do @(posedge clk); while (cfg_if.ready !== 1'b1);
    ledger.ignore_crc = v;
    cfg_if.valid <= 1'b0;
  endtask

  // Append the big-endian CRC of everything queued so far.
  task append_crc();
    logic [31:0] c;
    c = '0;
    foreach (stream_q[i]) c = crc32_shift_byte(c, stream_q[i]);
    put_byte(c[31:24]);
    put_byte(c[23:16]);
    put_byte(c[15:8]);
    put_byte(c[7:0]);
  endtask

  // Fill the field area up to stop; an overrun stream lets the last field spill.
  task fill_fields(int stop, flavor_t flavor);
    int         room;
    int         len;
    int         pick;
    logic [7:0] tag;
    bit         planted;
    planted = 1'b0;
    while (stream_q.size() < stop) begin
      room = stop - stream_q.size();
      tag = 8'($urandom);
      if (flavor == S_BAD_LEN && !planted && (room <= 2 || $urandom_range(0, 3) == 0)) begin
        tag[1:0] = 2'b00;
        put_byte(tag);
        put_byte(8'($urandom_range(128, 255)));
        planted = 1'b1;
      end else begin
        pick = $urandom_range(0, 5);
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 12);
        if (flavor != S_OVERRUN) begin
          if ((pick == 2 && room < 2) || (pick == 3 && room < 5) || (pick >= 4 && room < 2))
            pick = 0;
          if (pick >= 4 && len > room - 2) len = room - 2;
        end
        case (pick)
          0: put_byte(NOP_TAG);
          1: begin
            tag[1:0] = 2'b11;
            put_byte(tag);
          end
          2: begin
            tag[1:0] = 2'b10;
            put_byte(tag);
            put_byte(8'($urandom));
          end
          3: begin
            tag[1:0] = 2'b01;
            put_byte(tag);
            repeat (4) put_byte(8'($urandom));
          end
          default: begin
            tag[1:0] = 2'b00;
            put_byte(tag);
            put_byte(8'(len));
            repeat (len) put_byte(8'($urandom));
          end
        endcase
      end
    end
    while (stream_q.size() > stop) void'(stream_q.pop_back());
  endtask

  // Build one stream: noise, an oversized header, or a header plus any chosen fault.
  task make_stream(flavor_t flavor);
    int size;
    int h;
    int n;
    int idx;
    stream_q.delete();
    case (flavor)
      S_NOISE: begin
        repeat ($urandom_range(1, 24)) put_byte(8'($urandom));
      end
      S_HUGE: begin
        foreach (SIGNATURE[i]) put_byte(SIGNATURE[i]);
        put_byte(8'hFF);
        n = $urandom_range(16, 40);
        while (stream_q.size() < n) put_byte(8'($urandom));
      end
      default: begin
        size = ($urandom_range(0, 9) == 0) ? $urandom_range(3, 6) : $urandom_range(1, 2);
        h = size * 16;
        foreach (SIGNATURE[i]) put_byte(SIGNATURE[i]);
        put_byte(8'(size));
        fill_fields(h - 4, flavor);
        append_crc();
        repeat ($urandom_range(0, 3)) put_byte(8'($urandom));
        case (flavor)
          S_CRC_HIT: begin
            idx = $urandom_range(5, h - 1);
            stream_q[idx] = stream_q[idx] ^ 8'($urandom_range(1, 255));
          end
          S_SIG_HIT: begin
            idx = $urandom_range(0, 3);
            stream_q[idx] = stream_q[idx] ^ 8'($urandom_range(1, 255));
          end
          S_SIZE_ZERO: stream_q[4] = 8'h00;
          S_CUT: begin
            n = $urandom_range(1, stream_q.size() - 1);
            while (stream_q.size() > n) void'(stream_q.pop_back());
          end
          default: ;
        endcase
      end
    endcase
  endtask

  function automatic flavor_t pick_flavor();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return S_GOOD;
    if (r < 60) return S_OVERRUN;
    if (r < 66) return S_BAD_LEN;
    if (r < 74) return S_CRC_HIT;
    if (r < 79) return S_SIG_HIT;
    if (r < 83) return S_SIZE_ZERO;
    if (r < 91) return S_CUT;
    if (r < 95) return S_HUGE;
    return S_NOISE;
  endfunction

  // Main sequence: reset, directed streams, then four random phases.
  initial begin
    int budget;
    ledger = new();
    calm = 1'b0;
    rst_n <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.data_byte <= '0;
    in_if.last <= 1'b0;
    cfg_if.valid <= 1'b0;
    cfg_if.data <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // A stream too short to hold a header.
    stream_q = '{8'h41, 8'h69};
    send_stream();
    // Smallest header: empty, padding, one-byte, zero-length and empty fields.
    stream_q = '{8'h41, 8'h69, 8'h30, 8'hB9, 8'h01, 8'h07, 8'hFF, 8'h02, 8'hA5, 8'h00,
                 8'h00, 8'h83};
    append_crc();
    send_stream();
    drain_results();

    // Random phases; the CRC override alternates between its two settings.
    for (int ph = 0; ph < 4; ph++) begin
      if (ph > 0) write_ignore_crc(ph % 2);
      budget = 0;
      while (budget < PHASE_BYTES) begin
        calm = ($urandom_range(0, 4) == 0);
        make_stream(pick_flavor());
        budget += stream_q.size();
        send_stream();
      end
      calm = 1'b0;
      drain_results();
    end

    $display("Sent %0d bytes; checked %0d results, %0d mismatches.", ledger.bytes_seen,
             ledger.checked, ledger.mismatches);
    $display("Verdicts ok/short/sig/size/crc/len/overrun: %0d/%0d/%0d/%0d/%0d/%0d/%0d",
             ledger.verdicts_by_status[0], ledger.verdicts_by_status[1],
             ledger.verdicts_by_status[2], ledger.verdicts_by_status[3],
             ledger.verdicts_by_status[4], ledger.verdicts_by_status[5],
             ledger.verdicts_by_status[6]);
    if (ledger.mismatches == 0 && ledger.expected_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/ihtc_pkg.sv
hw/rtl/ihtc_if.sv
hw/rtl/image_header_tlv_checker_top.sv
dv/image_header_tlv_checker_top_tb.sv
